@@ hdl/service_failover_selector_macros.svh @@
// Assertion macros used by the checker of the failover selector.
// Needs clk and rst_n in scope at the point of use.
`ifndef SERVICE_FAILOVER_SELECTOR_MACROS_SVH
`define SERVICE_FAILOVER_SELECTOR_MACROS_SVH

// Property that must hold at every edge out of reset.
`define SFS_ASSERT(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("sfs check failed");

// Antecedent this cycle implies consequent in the next cycle.
`define SFS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sfs check failed");

`endif

@@ hdl/sfs_pkg.sv @@
// Shared types, constants and helpers for the service failover selector.
// No dependencies.
`default_nettype none

package sfs_pkg;

  localparam int SVC_W           = 4;
  localparam int RUN_W           = 8;
  localparam int MASK_W          = 8;
  localparam int CNT_W           = 4;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 8;
  localparam int MAX_SECONDARIES = 8;

  localparam logic [RUN_W-1:0] RUN_MAX          = '1;
  localparam logic [RUN_W-1:0] FAILOVER_THR_RST = RUN_W'(3);
  localparam logic [RUN_W-1:0] SWBACK_THR_RST   = RUN_W'(3);
  localparam logic [CNT_W-1:0] SEC_COUNT_RST    = CNT_W'(1);
  localparam logic [CNT_W-1:0] SEC_COUNT_MAX    = CNT_W'(MAX_SECONDARIES);
  localparam logic [SVC_W-1:0] SVC_PRIMARY      = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FAILOVER_THRESHOLD    = 2'd0,
    CFG_SWITCH_BACK_THRESHOLD = 2'd1,
    CFG_SECONDARY_COUNT       = 2'd2
  } sfs_cfg_idx_t;

  typedef struct packed {
    logic [RUN_W-1:0] failover_threshold;
    logic [RUN_W-1:0] switch_back_threshold;
    logic [CNT_W-1:0] secondary_count;
  } sfs_cfg_t;

  typedef struct packed {
    logic              primary_up;
    logic [MASK_W-1:0] secondary_up_mask;
  } sfs_in_t;

  typedef struct packed {
    logic [SVC_W-1:0] selected_service;
    logic             switched;
    logic [RUN_W-1:0] failures_seen;
  } sfs_out_t;

  typedef struct packed {
    logic [SVC_W-1:0] current_service;
    logic [RUN_W-1:0] failure_run;
    logic [RUN_W-1:0] recovery_run;
  } sfs_state_t;

  function automatic logic [RUN_W-1:0] sat_inc(input logic [RUN_W-1:0] v);
    sat_inc = (v == RUN_MAX) ? RUN_MAX : v + RUN_W'(1);
  endfunction

endpackage

`default_nettype wire

@@ hdl/sfs_cfg_regs.sv @@
// Configuration register file of the failover selector.
// Depends on sfs_pkg.
`default_nettype none

module sfs_cfg_regs (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [sfs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [sfs_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output sfs_pkg::sfs_cfg_t                     cfg
);

  sfs_pkg::sfs_cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        sfs_pkg::CFG_FAILOVER_THRESHOLD: begin
          cfg_nxt.failover_threshold = cfg_wdata[sfs_pkg::RUN_W-1:0];
        end
        sfs_pkg::CFG_SWITCH_BACK_THRESHOLD: begin
          cfg_nxt.switch_back_threshold = cfg_wdata[sfs_pkg::RUN_W-1:0];
        end
        sfs_pkg::CFG_SECONDARY_COUNT: begin
          cfg_nxt.secondary_count = cfg_wdata[sfs_pkg::CNT_W-1:0];
        end
        default: begin
          cfg_nxt = cfg_r; // unmapped index, dropped
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.failover_threshold    <= sfs_pkg::FAILOVER_THR_RST;
      cfg_r.switch_back_threshold <= sfs_pkg::SWBACK_THR_RST;
      cfg_r.secondary_count       <= sfs_pkg::SEC_COUNT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

@@ hdl/sfs_step.sv @@
// Next-state and result logic for one health check.
// Purely combinational; depends on sfs_pkg.
`default_nettype none

module sfs_step (
  input  wire sfs_pkg::sfs_cfg_t   cfg,
  input  wire sfs_pkg::sfs_state_t st,
  input  wire sfs_pkg::sfs_in_t    req,
  output sfs_pkg::sfs_state_t      st_nxt,
  output sfs_pkg::sfs_out_t        res
);

  logic [sfs_pkg::CNT_W-1:0] limit;
  logic                      found;
  logic [sfs_pkg::SVC_W-1:0] found_svc;
  logic [sfs_pkg::SVC_W-1:0] sec_idx;
  logic                      sec_ok;
  logic [sfs_pkg::RUN_W-1:0] fail_inc;
  logic [sfs_pkg::RUN_W-1:0] rec_inc;
  logic                      fail_trip;
  logic                      sw;

  // Lowest-numbered healthy secondary below the clamped count
  always_comb begin
    limit = (cfg.secondary_count > sfs_pkg::SEC_COUNT_MAX) ?
            sfs_pkg::SEC_COUNT_MAX : cfg.secondary_count;
    found     = 1'b0;
    found_svc = sfs_pkg::SVC_PRIMARY;
    for (int k = sfs_pkg::MASK_W - 1; k >= 0; k--) begin
      if (req.secondary_up_mask[k] && (sfs_pkg::CNT_W'(k) < limit)) begin
        found     = 1'b1;
        found_svc = sfs_pkg::SVC_W'(k + 1);
      end
    end
  end

  always_comb begin
    sec_idx   = st.current_service - sfs_pkg::SVC_W'(1);
    sec_ok    = (sec_idx < sfs_pkg::SVC_W'(sfs_pkg::MASK_W)) &&
                req.secondary_up_mask[sec_idx[2:0]];
    fail_inc  = sfs_pkg::sat_inc(st.failure_run);
    rec_inc   = sfs_pkg::sat_inc(st.recovery_run);
    st_nxt    = st;
    sw        = 1'b0;
    fail_trip = 1'b0;

    if (st.current_service == sfs_pkg::SVC_PRIMARY) begin
      if (req.primary_up) begin
        st_nxt.failure_run = '0;
      end else begin
        st_nxt.failure_run = fail_inc;
        if ((fail_inc >= cfg.failover_threshold) && found) begin
          sw                     = 1'b1;
          st_nxt.current_service = found_svc;
          st_nxt.failure_run     = '0;
          st_nxt.recovery_run    = '0;
        end
      end
    end else begin
      st_nxt.failure_run = sec_ok ? '0 : fail_inc;
      fail_trip          = !sec_ok && (fail_inc >= cfg.failover_threshold);
      if (!req.primary_up) begin
        st_nxt.recovery_run = '0;
      end else if (fail_trip || (rec_inc >= cfg.switch_back_threshold)) begin
        // failover to a healthy primary, or wait-to-restore expired
        sw                     = 1'b1;
        st_nxt.current_service = sfs_pkg::SVC_PRIMARY;
        st_nxt.failure_run     = '0;
        st_nxt.recovery_run    = '0;
      end else begin
        st_nxt.recovery_run = rec_inc;
      end
    end

    res.selected_service = st_nxt.current_service;
    res.switched         = sw;
    res.failures_seen    = st_nxt.failure_run;
  end

endmodule

`default_nettype wire

@@ hdl/service_failover_selector.sv @@
// Top level of the primary/backup service failover selector.
// Depends on sfs_pkg, sfs_cfg_regs and sfs_step.
//
// Usage
// - Input channel (in_valid / in_stall / in_data): one request per periodic
//   health check, carrying primary_up and secondary_up_mask.
// - Result channel (out_valid / out_stall / out_data): exactly one result per
//   request, in order: selected service, a switched flag, the failure run.
// - Config port (cfg_we / cfg_index / cfg_wdata): single-cycle writes of
//   failover_threshold, switch_back_threshold and secondary_count. Write only
//   while no request is in flight; unmapped indexes are ignored.
// - Path: when not stalled, an accepted request passes the input register,
//   then the result register, where out_valid rises and the result can be
//   taken. Throughput: one request per cycle while the receiver does not
//   stall; the selection state updates in the same cycle a request moves to
//   the result register, so consecutive checks chain without bubbles.
// - Receiver stall: the result register holds; one more request may sit in
//   the input register, after which in_stall rises.
// - Reset (rst_n low, synchronous): primary selected, both runs cleared,
//   registers back to 3 / 3 / 1, both stages emptied.
`default_nettype none

module service_failover_selector (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // health-check requests
  input  wire logic                           in_valid,
  output      logic                           in_stall,
  input  wire sfs_pkg::sfs_in_t               in_data,
  // results
  output      logic                           out_valid,
  input  wire logic                           out_stall,
  output sfs_pkg::sfs_out_t                   out_data,
  // configuration
  input  wire logic                           cfg_we,
  input  wire logic [sfs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [sfs_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  sfs_pkg::sfs_cfg_t   cfg;
  sfs_pkg::sfs_state_t st_r, st_nxt, st_calc;
  sfs_pkg::sfs_in_t    s1_data_r;
  sfs_pkg::sfs_out_t   out_data_r, out_data_nxt, res_calc;
  logic                s1_valid_r, s1_valid_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_free;
  logic                advance;
  logic                in_take;

  sfs_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  sfs_step u_step (
    .cfg    (cfg),
    .st     (st_r),
    .req    (s1_data_r),
    .st_nxt (st_calc),
    .res    (res_calc)
  );

  // Result register frees up when empty or being drained this cycle
  assign out_free = !out_valid_r || !out_stall;
  assign advance  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt  = in_take ? 1'b1 : (advance ? 1'b0 : s1_valid_r);
    out_valid_nxt = advance ? 1'b1 : (out_valid_r && out_stall);
    st_nxt        = advance ? st_calc : st_r;
    out_data_nxt  = advance ? res_calc : out_data_r;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      st_r        <= st_nxt;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data_r <= in_data;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

@@ hdl/sfs_checker.sv @@
// Port-level checks for the failover selector, bound to its top level.
// Depends on sfs_pkg and service_failover_selector_macros.svh.
`default_nettype none

`include "service_failover_selector_macros.svh"

module sfs_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire sfs_pkg::sfs_out_t out_data
);

  logic in_take;
  assign in_take = in_valid && !in_stall;

  // a stalled result holds
  `SFS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

  // back-pressure only when a result is waiting and stalled
  `SFS_ASSERT(a_stall_cause, !in_stall || (out_valid && out_stall))

  // any switch clears the failure run
  `SFS_ASSERT(a_switch_clears, !(out_valid && out_data.switched) ||
              (out_data.failures_seen == '0))

  // selection never lies beyond the last addressable secondary
  `SFS_ASSERT(a_svc_range, !out_valid ||
              (out_data.selected_service <= sfs_pkg::SVC_W'(sfs_pkg::MAX_SECONDARIES)))

  // a request taken while the result side is empty is followed by a valid result
  `SFS_ASSERT_NEXT(a_no_loss, in_take && !out_valid, ##1 out_valid)

endmodule

bind service_failover_selector sfs_checker u_sfs_checker (.*);

`default_nettype wire

@@ verif/tb_service_failover_selector.sv @@
// Testbench for service_failover_selector: drives health-check requests, predicts each
// result with an in-bench model of the selection logic and checks it field by field.
// Depends on sfs_pkg and the RTL of the block only.
module tb_service_failover_selector;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD    = 10;
  localparam int SETTLE_CYCLES = 4;      // two-stage pipe plus margin
  localparam int HOLD_OFF_LEN  = 40;     // long receiver hold-off, in cycles
  localparam int MAX_REPORTS   = 40;
  localparam int TIMEOUT_NS    = 6_000_000;
  // index 3 has no register behind it; a write there must change nothing
  localparam logic [sfs_pkg::CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

  logic clk = 1'b0;
  logic rst_n;

  logic                           in_valid;
  logic                           in_stall;
  sfs_pkg::sfs_in_t               in_data;
  logic                           out_valid;
  logic                           out_stall;
  sfs_pkg::sfs_out_t              out_data;
  logic                           cfg_we;
  logic [sfs_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [sfs_pkg::CFG_DATA_W-1:0] cfg_wdata;

  service_failover_selector dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Selection model: own copy of the registers and of the selection state.
  // ---------------------------------------------------------------------------
  logic [sfs_pkg::RUN_W-1:0] thr_failover    = sfs_pkg::FAILOVER_THR_RST;
  logic [sfs_pkg::RUN_W-1:0] thr_switch_back = sfs_pkg::SWBACK_THR_RST;
  logic [sfs_pkg::CNT_W-1:0] n_secondaries   = sfs_pkg::SEC_COUNT_RST;

  logic [sfs_pkg::SVC_W-1:0] sel_service         = sfs_pkg::SVC_PRIMARY;
  logic [sfs_pkg::RUN_W-1:0] fail_streak         = '0;
  logic [sfs_pkg::RUN_W-1:0] good_primary_streak = '0;

  sfs_pkg::sfs_out_t expected_selections[$];   // one per accepted request, oldest first

  int err_count     = 0;
  int checked_count = 0;

  // Knobs shared between the test tasks and the result-side process
  bit src_jitter  = 1'b1;
  bit sink_jitter = 1'b1;
  int hold_len    = 0;

  // Streak counters stick at all-ones
  function automatic logic [sfs_pkg::RUN_W-1:0] streak_up(
      input logic [sfs_pkg::RUN_W-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  // Changing service wipes both streaks; re-selecting the same one is no switch
  function automatic logic move_to(input logic [sfs_pkg::SVC_W-1:0] svc);
    if (svc == sel_service) return 1'b0;
    sel_service         = svc;
    fail_streak         = '0;
    good_primary_streak = '0;
    return 1'b1;
  endfunction

  // Wait-to-restore: count good primary checks while on a secondary
  function automatic logic wait_restore(input logic primary_ok);
    if (!primary_ok) begin
      good_primary_streak = '0;
      return 1'b0;
    end
    good_primary_streak = streak_up(good_primary_streak);
    return (good_primary_streak >= thr_switch_back) ? move_to(sfs_pkg::SVC_PRIMARY) : 1'b0;
  endfunction

  function automatic sfs_pkg::sfs_out_t predict_check(input sfs_pkg::sfs_in_t chk);
    sfs_pkg::sfs_out_t res;
    logic              sw;
    int                limit;
    logic              cur_ok;
    sw = 1'b0;
    if (sel_service == sfs_pkg::SVC_PRIMARY) begin
      if (chk.primary_up) begin
        fail_streak = '0;
      end else begin
        fail_streak = streak_up(fail_streak);
        if (fail_streak >= thr_failover) begin
          // counts above the maximum behave as the maximum
          limit = (n_secondaries > sfs_pkg::SEC_COUNT_MAX) ?
                  sfs_pkg::MAX_SECONDARIES : int'(n_secondaries);
          for (int k = 0; k < limit; k++)
            if (!sw && chk.secondary_up_mask[k]) sw = move_to(sfs_pkg::SVC_W'(k + 1));
        end
      end
    end else begin
      // a stale selection (count lowered below it) is still judged by its own bit
      cur_ok = chk.secondary_up_mask[3'(sel_service - 1'b1)];
      if (cur_ok) begin
        fail_streak = '0;
        sw = wait_restore(chk.primary_up);
      end else begin
        fail_streak = streak_up(fail_streak);
        if (fail_streak < thr_failover) sw = wait_restore(chk.primary_up);
        else if (chk.primary_up)        sw = move_to(sfs_pkg::SVC_PRIMARY);
        else                            sw = wait_restore(1'b0);
      end
    end
    res.selected_service = sel_service;
    res.switched         = sw;
    res.failures_seen    = fail_streak;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Helpers
  // ---------------------------------------------------------------------------
  function automatic sfs_pkg::sfs_in_t health(input logic up,
                                              input logic [sfs_pkg::MASK_W-1:0] mask);
    sfs_pkg::sfs_in_t c;
    c.primary_up        = up;
    c.secondary_up_mask = mask;
    return c;
  endfunction

  // Mostly back-to-back, some short gaps, the odd long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string msg);
    if (err_count < MAX_REPORTS) $display("[%0t] mismatch: %s", $realtime, msg);
    err_count++;
  endtask

  // Offer one request; the prediction is taken at the edge it is accepted.
  // Valid is only touched once per edge, so back-to-back requests keep it high.
  task automatic send_check(input sfs_pkg::sfs_in_t chk);
    int gap;
    gap = src_jitter ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= chk;
    do @(posedge clk); while (in_stall);
    expected_selections.push_back(predict_check(chk));
  endtask

  // Sender pauses until every result is back; the block is idle afterwards
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (expected_selections.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Single register write; call only while idle
  task automatic write_reg(input logic [sfs_pkg::CFG_IDX_W-1:0] idx,
                           input logic [sfs_pkg::CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      sfs_pkg::CFG_FAILOVER_THRESHOLD:    thr_failover    = val;
      sfs_pkg::CFG_SWITCH_BACK_THRESHOLD: thr_switch_back = val;
      sfs_pkg::CFG_SECONDARY_COUNT:       n_secondaries   = val[sfs_pkg::CNT_W-1:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_thresholds(input logic [7:0] fo, input logic [7:0] sb,
                                input logic [3:0] cnt);
    write_reg(sfs_pkg::CFG_FAILOVER_THRESHOLD, fo);
    write_reg(sfs_pkg::CFG_SWITCH_BACK_THRESHOLD, sb);
    write_reg(sfs_pkg::CFG_SECONDARY_COUNT, sfs_pkg::CFG_DATA_W'(cnt));
  endtask

  // Random requests in episodes: a bias on the primary and a base mask held for
  // a few checks, so streaks build up and the thresholds are actually reached.
  task automatic run_random_checks(input int n_checks);
    int                         left;
    int                         ep_len;
    int                         up_pct;
    logic [sfs_pkg::MASK_W-1:0] base_mask;
    sfs_pkg::sfs_in_t           c;
    left = n_checks;
    while (left > 0) begin
      ep_len = $urandom_range(1, 12);
      case ($urandom_range(0, 4))
        0:       up_pct = 0;
        1:       up_pct = 10;
        2:       up_pct = 90;
        3:       up_pct = 100;
        default: up_pct = 50;
      endcase
      case ($urandom_range(0, 3))
        0:       base_mask = '0;
        1:       base_mask = '1;
        2:       base_mask = sfs_pkg::MASK_W'(1) << $urandom_range(0, sfs_pkg::MASK_W - 1);
        default: base_mask = sfs_pkg::MASK_W'($urandom);
      endcase
      for (int i = 0; i < ep_len && left > 0; i++) begin
        c.primary_up        = ($urandom_range(0, 99) < up_pct);
        c.secondary_up_mask = base_mask;
        // occasional flap of one secondary
        if ($urandom_range(0, 4) == 0)
          c.secondary_up_mask ^= sfs_pkg::MASK_W'(1) << $urandom_range(0, sfs_pkg::MASK_W - 1);
        send_check(c);
        left--;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Registers at reset (3 / 3 / 1): fail over, fail while on a secondary,
  // come back by wait-to-restore and by secondary failure with primary up.
  task automatic test_reset_defaults();
    send_check(health(1'b1, 8'hFF));
    repeat (3) send_check(health(1'b0, 8'h00));   // no secondary up: stays on primary
    send_check(health(1'b0, 8'h01));              // fail over to secondary 0
    send_check(health(1'b0, 8'h00));
    repeat (3) send_check(health(1'b1, 8'h01));   // wait-to-restore back to primary
    repeat (4) send_check(health(1'b0, 8'hFE));   // only secondary 0 counts: none up
    send_check(health(1'b0, 8'h01));              // over again
    repeat (2) send_check(health(1'b0, 8'h00));
    send_check(health(1'b1, 8'h00));              // secondary fails out, primary up
    wait_results_drained();
  endtask

  // Both thresholds zero, count above the maximum, and a write to the spare index
  task automatic test_threshold_extremes();
    set_thresholds(8'd0, 8'd0, 4'd15);
    write_reg(CFG_SPARE_IDX, 8'h00);
    send_check(health(1'b0, 8'h80));   // only the top secondary up: selected
    send_check(health(1'b1, 8'h80));   // one good primary check restores at once
    send_check(health(1'b1, 8'hFF));
    send_check(health(1'b0, 8'h00));
    send_check(health(1'b0, 8'h01));
    send_check(health(1'b0, 8'h00));   // secondary down, primary down: stay
    send_check(health(1'b0, 8'h01));
    send_check(health(1'b1, 8'h00));   // secondary down, primary up: back
    wait_results_drained();
  endtask

  // Count lowered below the secondary in use, then count zero
  task automatic test_stale_selection();
    set_thresholds(8'd1, 8'd255, 4'd8);
    send_check(health(1'b0, 8'h10));   // to secondary 4
    wait_results_drained();
    write_reg(sfs_pkg::CFG_SECONDARY_COUNT, 8'd2);
    send_check(health(1'b0, 8'h10));   // still judged by its own bit
    send_check(health(1'b1, 8'h10));
    send_check(health(1'b0, 8'h00));
    send_check(health(1'b1, 8'h00));   // back to primary
    send_check(health(1'b0, 8'h13));   // only the first two now eligible
    send_check(health(1'b1, 8'h00));
    wait_results_drained();
    write_reg(sfs_pkg::CFG_SECONDARY_COUNT, 8'd0);
    send_check(health(1'b0, 8'hFF));   // no secondaries configured at all
    wait_results_drained();
  endtask

  // Failure streak running into its ceiling, on the primary and on a secondary
  task automatic test_streak_saturation();
    logic [sfs_pkg::MASK_W-1:0] m;
    set_thresholds(8'd255, 8'd255, 4'd0);
    repeat (262) send_check(health(1'b0, sfs_pkg::MASK_W'($urandom)));
    send_check(health(1'b1, sfs_pkg::MASK_W'($urandom)));
    wait_results_drained();
    set_thresholds(8'd1, 8'd255, 4'd8);
    send_check(health(1'b0, 8'h04));   // to secondary 2
    wait_results_drained();
    write_reg(sfs_pkg::CFG_FAILOVER_THRESHOLD, 8'd255);
    repeat (262) begin
      m = sfs_pkg::MASK_W'($urandom) & ~8'h04;
      send_check(health(1'b0, m));
    end
    m = sfs_pkg::MASK_W'($urandom) & ~8'h04;
    send_check(health(1'b1, m));       // streak at the top meets 255: back
    wait_results_drained();
  endtask

  // Receiver holds off while requests keep coming, so the block fills up and
  // stalls its input; then the sender waits until everything has come back.
  task automatic test_back_pressure();
    set_thresholds(8'd2, 8'd2, 4'd4);
    src_jitter = 1'b0;
    hold_len   = HOLD_OFF_LEN;
    run_random_checks(24);
    wait_results_drained();
    src_jitter = 1'b1;
  endtask

  task automatic test_random_phases();
    logic [7:0] fo;
    logic [7:0] sb;
    for (int ph = 0; ph < 6; ph++) begin
      fo = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 5)) : 8'($urandom_range(0, 255));
      sb = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 5)) : 8'($urandom_range(0, 255));
      set_thresholds(fo, sb, 4'($urandom_range(0, 15)));
      // one phase runs flat out on both sides
      src_jitter  = (ph != 2);
      sink_jitter = (ph != 2);
      run_random_checks(20);
      wait_results_drained();
    end
    src_jitter  = 1'b1;
    sink_jitter = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stalls, plus the long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int n;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_len > 0) begin
        n        = hold_len;
        hold_len = 0;
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end else if (sink_jitter && $urandom_range(0, 3) == 0) begin
        n = pick_gap();
        if (n == 0) n = 1;
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Every accepted result against the oldest prediction
  always @(posedge clk) begin : result_check
    sfs_pkg::sfs_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      checked_count++;
      if (expected_selections.size() == 0) begin
        report_mismatch($sformatf("result #%0d with no request outstanding", checked_count));
      end else begin
        want = expected_selections.pop_front();
        if (out_data.selected_service !== want.selected_service)
          report_mismatch($sformatf("result #%0d selected_service %0d, want %0d", checked_count,
                                    out_data.selected_service, want.selected_service));
        if (out_data.switched !== want.switched)
          report_mismatch($sformatf("result #%0d switched %0b, want %0b", checked_count,
                                    out_data.switched, want.switched));
        if (out_data.failures_seen !== want.failures_seen)
          report_mismatch($sformatf("result #%0d failures_seen %0d, want %0d", checked_count,
                                    out_data.failures_seen, want.failures_seen));
      end
    end
  end

  initial begin : watchdog
    #TIMEOUT_NS;
    $display("== FAIL ==");
    $finish;
  end

  initial begin : test_sequence
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_threshold_extremes();
    test_stale_selection();
    test_streak_saturation();
    test_back_pressure();
    test_random_phases();

    wait_results_drained();
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
